/* hw/rtl/stac_pkg.sv */
// ----------------------------------------------------------------------------
// stac_pkg
// Shared types and constants of the segment table allocate/check core.
// ----------------------------------------------------------------------------
package stac_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam int SEG_W    = 8;
	localparam int BASE_W   = 10;
	localparam int OFF_W    = 10;
	localparam int LIMIT_W  = BASE_W + OFF_W;	// base*1024 + offset
	localparam int STATUS_W = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

	// request kinds
	localparam logic KIND_ALLOC  = 1'b0;
	localparam logic KIND_ACCESS = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAULT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// register indexes
	localparam logic REG_MEM_AVAIL = 1'b0;

	typedef struct packed {
		logic [SEG_W-1:0]  segment;
		logic [BASE_W-1:0] base;
		logic [OFF_W-1:0]  offset;
	} entry_t;

	typedef struct packed {
		logic              kind;
		logic [SEG_W-1:0]  segment;
		logic [BASE_W-1:0] base;
		logic [OFF_W-1:0]  offset;
	} req_t;

endpackage

/* hw/rtl/stac_table.sv */
// ----------------------------------------------------------------------------
// stac_table
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stac_table #(
	parameter int DEPTH = stac_pkg::TABLE_DEPTH_DEF,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  stac_pkg::entry_t wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output stac_pkg::entry_t rd_data
);
	import stac_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/stac_ctrl.sv */
// ----------------------------------------------------------------------------
// stac_ctrl
// Request sequencer: limit check, linear scan of the stored entries, append.
// ----------------------------------------------------------------------------
module stac_ctrl #(
	parameter int DEPTH = stac_pkg::TABLE_DEPTH_DEF,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  stac_pkg::req_t                req,
	input  logic [stac_pkg::LIMIT_W-1:0]  mem_available,
	output logic                          busy,
	output logic                          done,
	output logic [stac_pkg::STATUS_W-1:0] status,
	output logic                          rd_en,
	output logic [IDX_W-1:0]              rd_addr,
	input  stac_pkg::entry_t              rd_data,
	output logic                          wr_en,
	output logic [IDX_W-1:0]              wr_addr,
	output stac_pkg::entry_t              wr_data
);
	import stac_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	req_t             req_q;
	logic             limit_fail_q;
	logic             hit_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             rd_vld_s1;

	logic issue;
	logic match;
	logic full;
	logic [STATUS_W-1:0] status_c;

	assign issue = (state_q == S_SCAN) && (ptr_q < count_q);
	assign full  = (count_q == CNT_W'(DEPTH));

	// allocate looks for a base clash, access for a covering entry
	always_comb begin
		if (req_q.kind == KIND_ALLOC) begin
			match = (rd_data.base == req_q.base);
		end else begin
			match = (rd_data.segment == req_q.segment) &&
			        (rd_data.base == req_q.base) &&
			        (rd_data.offset >= req_q.offset);
		end
	end

	always_comb begin
		if (req_q.kind == KIND_ALLOC) begin
			if (limit_fail_q || hit_q) begin
				status_c = ST_FAULT;
			end else if (full) begin
				status_c = ST_FULL;
			end else begin
				status_c = ST_OK;
			end
		end else begin
			status_c = hit_q ? ST_OK : ST_FAULT;
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = (state_q == S_DONE);
	assign status  = status_c;
	assign rd_en   = issue;
	assign rd_addr = ptr_q[IDX_W-1:0];
	assign wr_en   = done && (req_q.kind == KIND_ALLOC) && (status_c == ST_OK);
	assign wr_addr = count_q[IDX_W-1:0];
	assign wr_data = '{segment: req_q.segment, base: req_q.base, offset: req_q.offset};

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q        <= req;
			limit_fail_q <= (mem_available < {req.base, req.offset});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			hit_q     <= 1'b0;
			ptr_q     <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						hit_q   <= 1'b0;
						ptr_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (rd_vld_s1 && match) begin
						hit_q <= 1'b1;
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (wr_en) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/segment_table_alloc_check_core.sv */
// ----------------------------------------------------------------------------
// segment_table_alloc_check_core
// Segment table with allocate and access checks against a memory limit.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                      | word
//  ----------+--------------------------------+----------------------------------
//  request   | start & !busy                  | kind, segment_number, base_unit,
//            |                                | offset
//  result    | done (one cycle, no back-press)| status
//  config    | psel & penable & pwrite        | paddr, pwdata (mem_available)
//
//  Scan: the sequencer reads one stored entry a cycle through the single read
//  port, then waits for the last registered read before the result strobe; a
//  new request is taken only after the result of the last one. Reset clears
//  the fill count: table empty at once, no clearing pass. The receiver cannot
//  stall; busy drops after the result cycle and the next word is taken the
//  cycle after.
//
module segment_table_alloc_check_core #(
	parameter int TABLE_DEPTH = stac_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [stac_pkg::SEG_W-1:0]    segment_number,
	input  logic [stac_pkg::BASE_W-1:0]   base_unit,
	input  logic [stac_pkg::OFF_W-1:0]    offset,
	// result
	output logic                          done,
	output logic [stac_pkg::STATUS_W-1:0] status,
	// config
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import stac_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [LIMIT_W-1:0] mem_available_q;
	logic               reg_sel;
	req_t               req;

	logic       rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t     rd_data;
	logic       wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t     wr_data;

	// ---- config port: one register at byte address 0 ----
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_MEM_AVAIL);
	assign prdata  = reg_sel ? {{(32-LIMIT_W){1'b0}}, mem_available_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_available_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			mem_available_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign req = '{kind: kind, segment: segment_number, base: base_unit, offset: offset};

	// ---- sequencer ----
	stac_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req           (req),
		.mem_available (mem_available_q),
		.busy          (busy),
		.done          (done),
		.status        (status),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	// ---- entry store: entries are appended, so the fill count marks valid ----
	stac_table #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

`ifndef ASSERT_OFF
	// an accepted request keeps the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after start");

	// result strobe lasts one cycle and lies inside the busy window
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !done) else $error("result strobe not single-cycle");

	// no table write outside the result cycle
	a_wr_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> done && status == ST_OK) else $error("stray table write");

	// the returned status is a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_FAULT || status == ST_FULL))
		else $error("undefined status code");
`endif

endmodule
